// File: sv/u8u2_pkg.sv
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared widths, byte patterns and the lead byte length decode for the
// UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u2_pkg;

   localparam int BYTE_W      = 8;
   localparam int CODE_W      = 16;
   localparam int SEQ_LEN_W   = 3;
   localparam int PAYLOAD_W   = 6;

   // longest sequence the decoder can be built for, and the default
   localparam int MAX_SEQ_LEN_LIMIT   = 6;
   localparam int MAX_SEQ_LEN_DEFAULT = 6;

   // byte patterns
   localparam logic [BYTE_W-1:0] LEAD_MIN      = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD2_MASK    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK    = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK    = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD5_MASK    = 8'hFC;
   localparam logic [BYTE_W-1:0] LEAD6_MASK    = 8'hFE;
   localparam logic [BYTE_W-1:0] LEAD2_CODE    = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_CODE    = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD5_CODE    = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD6_CODE    = 8'hFC;
   localparam logic [BYTE_W-1:0] CONT_MASK     = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_CODE     = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD_BITS_ALL = 8'h7F;

   // sequence length announced by a lead byte, zero when it is no lead
   function automatic logic [SEQ_LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [SEQ_LEN_W-1:0] len;
      len = '0;
      if      ((b & LEAD2_MASK) == LEAD2_CODE) len = 3'd2;
      else if ((b & LEAD3_MASK) == LEAD3_CODE) len = 3'd3;
      else if ((b & LEAD4_MASK) == LEAD4_CODE) len = 3'd4;
      else if ((b & LEAD5_MASK) == LEAD5_CODE) len = 3'd5;
      else if ((b & LEAD6_MASK) == LEAD6_CODE) len = 3'd6;
      return len;
   endfunction

endpackage

`default_nettype wire

// File: sv/utf8_to_ucs2_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_unit
// Decodes a UTF-8 byte stream into 16-bit UCS-2 code units, passing bytes
// of broken or over-long sequences through raw and ending text on a zero.
// ----------------------------------------------------------------------------
//
//   channel   ports                                         direction
//   -------   -------------------------------------------   ---------
//   req       req_valid req_ready req_in_byte               in
//   rsp       rsp_valid rsp_ready rsp_code_unit             out
//             rsp_last_of_run rsp_end_of_text
//
// One byte is taken per cycle while results flow and no burst of several
// results drains; the decode itself is combinational from the input register
// into the burst register. A byte that causes k results holds the burst
// register until all k are taken, so a broken sequence flushes up to
// MAX_SEQUENCE_LENGTH results. The input register takes one more byte while a
// burst drains. Synchronous active-high reset closes any open sequence and
// empties both registers.
//
`default_nettype none

module utf8_to_ucs2_stream_decoder_unit #(
   parameter int MAX_SEQUENCE_LENGTH = u8u2_pkg::MAX_SEQ_LEN_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [u8u2_pkg::BYTE_W-1:0]   req_in_byte,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [u8u2_pkg::CODE_W-1:0]        rsp_code_unit,
   output logic                               rsp_last_of_run,
   output logic                               rsp_end_of_text
);

   localparam int BYTE_W    = u8u2_pkg::BYTE_W;
   localparam int CODE_W    = u8u2_pkg::CODE_W;
   localparam int SEQ_LEN_W = u8u2_pkg::SEQ_LEN_W;
   localparam int PAYLOAD_W = u8u2_pkg::PAYLOAD_W;

   // held continuations: every byte between lead and last
   localparam int HeldDepth = (MAX_SEQUENCE_LENGTH > 2) ? MAX_SEQUENCE_LENGTH - 2 : 1;
   localparam int HeldIdxW  = (HeldDepth > 1) ? $clog2(HeldDepth) : 1;
   // burst: lead, held bytes and the result of the failing byte
   localparam int BurstDepth = MAX_SEQUENCE_LENGTH;

   localparam logic [SEQ_LEN_W-1:0] MaxLen = SEQ_LEN_W'(MAX_SEQUENCE_LENGTH);
   localparam logic [SEQ_LEN_W-1:0] One    = SEQ_LEN_W'(1);

   // input register
   logic                     in_valid_ff;
   logic [BYTE_W-1:0]        in_byte_ff;

   // sequence state
   logic [SEQ_LEN_W-1:0]     seq_len_ff,  seq_len_in;
   logic [SEQ_LEN_W-1:0]     rcvd_ff,     rcvd_in;
   logic [CODE_W-1:0]        partial_ff,  partial_in;
   logic [BYTE_W-1:0]        lead_ff,     lead_in;
   logic [BYTE_W-1:0]        held_ff [HeldDepth];
   logic                     held_we;

   // burst register
   logic [CODE_W-1:0]        unit_ff [BurstDepth];
   logic [CODE_W-1:0]        unit_in [BurstDepth];
   logic [SEQ_LEN_W-1:0]     cnt_ff,  cnt_in;
   logic                     eot_ff,  eot_in;

   logic                     burst_load;
   logic                     rsp_fire;

   // decode intermediates
   logic [BYTE_W-1:0]        b;
   logic                     seq_open;
   logic                     is_cont;
   logic [SEQ_LEN_W-1:0]     lead_len;
   logic                     lead_ok;
   logic [SEQ_LEN_W-1:0]     held_cnt;
   logic                     fresh_emit;
   logic                     fresh_eot;
   logic [CODE_W-1:0]        fresh_unit;
   logic [CODE_W-1:0]        cont_code;
   logic [SEQ_LEN_W-1:0]     rcvd_next;

   // handshakes
   assign rsp_valid  = (cnt_ff != '0);
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign burst_load = in_valid_ff && ((cnt_ff == '0) || ((cnt_ff == One) && rsp_ready));
   assign req_ready  = !in_valid_ff || burst_load;

   assign rsp_code_unit   = unit_ff[0];
   assign rsp_last_of_run = (cnt_ff == One);
   assign rsp_end_of_text = eot_ff && (cnt_ff == One);

   // decode of the registered byte against the sequence state
   always_comb begin
      b          = in_byte_ff;
      seq_open   = (seq_len_ff != '0);
      is_cont    = ((b & u8u2_pkg::CONT_MASK) == u8u2_pkg::CONT_CODE);
      lead_len   = u8u2_pkg::lead_length(b);
      lead_ok    = (b >= u8u2_pkg::LEAD_MIN) && (lead_len >= 3'd2) && (lead_len <= MaxLen);
      held_cnt   = rcvd_ff - One;
      cont_code  = {partial_ff[CODE_W-PAYLOAD_W-1:0], b[PAYLOAD_W-1:0]};
      rcvd_next  = rcvd_ff + One;

      // fresh handling of the byte, as if no sequence were open
      fresh_eot  = (b == '0);
      fresh_emit = fresh_eot || !lead_ok;
      fresh_unit = fresh_eot ? '0 : CODE_W'(b);

      seq_len_in = seq_len_ff;
      rcvd_in    = rcvd_ff;
      partial_in = partial_ff;
      lead_in    = lead_ff;
      held_we    = 1'b0;
      cnt_in     = '0;
      eot_in     = 1'b0;
      for (int k = 0; k < BurstDepth; k++) begin
         unit_in[k] = fresh_unit;
      end

      if (seq_open && is_cont) begin
         // continuation byte extends the open sequence
         if (rcvd_next >= seq_len_ff) begin
            unit_in[0] = cont_code;
            cnt_in     = One;
            seq_len_in = '0;
            rcvd_in    = '0;
            partial_in = '0;
            lead_in    = '0;
         end else begin
            partial_in = cont_code;
            rcvd_in    = rcvd_next;
            held_we    = 1'b1;
         end
      end else begin
         // failed sequence flushes lead and held bytes raw first
         if (seq_open) begin
            for (int k = 0; k < BurstDepth; k++) begin
               if (k == 0) begin
                  unit_in[k] = CODE_W'(lead_ff);
               end else if (SEQ_LEN_W'(k) <= held_cnt && (k - 1) < HeldDepth) begin
                  unit_in[k] = CODE_W'(held_ff[HeldIdxW'(((k - 1) < HeldDepth) ? k - 1 : 0)]);
               end
            end
            cnt_in = One + held_cnt + SEQ_LEN_W'(fresh_emit);
         end else begin
            cnt_in = SEQ_LEN_W'(fresh_emit);
         end
         eot_in = fresh_eot;
         if (lead_ok) begin
            seq_len_in = lead_len;
            rcvd_in    = One;
            lead_in    = b;
            partial_in = CODE_W'(b & (u8u2_pkg::LEAD_BITS_ALL >> lead_len));
         end else begin
            seq_len_in = '0;
            rcvd_in    = '0;
            partial_in = '0;
            lead_in    = '0;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= '0;
         rcvd_ff    <= '0;
         partial_ff <= '0;
         lead_ff    <= '0;
      end else if (burst_load) begin
         seq_len_ff <= seq_len_in;
         rcvd_ff    <= rcvd_in;
         partial_ff <= partial_in;
         lead_ff    <= lead_in;
      end
   end

   // held continuation bytes, no reset
   always_ff @(posedge clock) begin
      if (burst_load && held_we) begin
         held_ff[HeldIdxW'(held_cnt)] <= b;
      end
   end

   // burst register, drains one result per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (burst_load) begin
         cnt_ff <= cnt_in;
      end else if (rsp_fire) begin
         cnt_ff <= cnt_ff - One;
      end
   end

   always_ff @(posedge clock) begin
      if (burst_load) begin
         eot_ff <= eot_in;
         for (int k = 0; k < BurstDepth; k++) begin
            unit_ff[k] <= unit_in[k];
         end
      end else if (rsp_fire) begin
         for (int k = 0; k < BurstDepth - 1; k++) begin
            unit_ff[k] <= unit_ff[k + 1];
         end
      end
   end

`ifndef NO_ASSERTIONS
   // burst never holds more than one full flush
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MaxLen)
      else $error("burst count beyond sequence limit");

   // an open sequence has its lead counted and is not yet complete
   a_seq_open : assert property (@(posedge clock) disable iff (reset)
      (seq_len_ff != '0) |-> (rcvd_ff != '0) && (rcvd_ff < seq_len_ff))
      else $error("open sequence with bad byte count");

   a_seq_closed : assert property (@(posedge clock) disable iff (reset)
      (seq_len_ff == '0) |-> (rcvd_ff == '0) && (partial_ff == '0))
      else $error("closed sequence keeps state");

   // terminator is the last result of its byte and carries zero
   a_eot : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_text) |-> rsp_last_of_run && (rsp_code_unit == '0))
      else $error("terminator not last or not zero");

   // empty input register always takes a byte
   a_ready : assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input register empty but not ready");
`endif

endmodule

`default_nettype wire
